// ----- rtl/kdb_pkg.sv -----
package kdb_pkg;

	// Number of debounced keys; keys beyond the raw field read as released.
	localparam int NUM_KEYS = 7;
	// Width of the raw key field and of the reported status words.
	localparam int RAW_W = 7;
	// Center key, the one that requests power off.
	localparam int CENTER_BIT = 6;

	localparam int LIMIT_W = 8;
	localparam int TICKS_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd3;
	localparam logic [TICKS_W-1:0] TURN_OFF_TICKS_RST = 32'd3000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_OFF_TICKS = 1'b1;

	typedef enum logic [1:0] {
		PH_RELEASED,
		PH_PRESS_DB,
		PH_PRESSED,
		PH_RELEASE_DB
	} kdb_phase_t;

	// Handshake inputs seen by the merge stage.
	typedef struct packed {
		logic in_valid;
		logic out_stall;
	} kdb_pipe_ctl_t;

	// Handshake outputs driven by the merge stage.
	typedef struct packed {
		logic in_stall;
		logic out_valid;
	} kdb_pipe_sts_t;

endpackage

// ----- rtl/kdb_key_lane.sv -----
module kdb_key_lane
	import kdb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               level,
	input  logic [LIMIT_W-1:0] limit,
	output logic               pressed
);

	kdb_phase_t         phase_q, phase_d;
	logic [LIMIT_W-1:0] count_q, count_d;
	logic               below_limit;

	assign below_limit = (count_q < limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RELEASED;
			count_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		pressed = 1'b0;
		unique case (phase_q)
			PH_RELEASED: begin
				if (!level) begin
					count_d = '0;
					phase_d = PH_PRESS_DB;
				end
			end
			PH_PRESS_DB: begin
				if (level) begin
					phase_d = PH_RELEASED;
				end else if (below_limit) begin
					count_d = count_q + 1'b1;
				end else begin
					pressed = 1'b1;
					phase_d = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				pressed = 1'b1;
				if (level) begin
					count_d = '0;
					phase_d = PH_RELEASE_DB;
				end
			end
			PH_RELEASE_DB: begin
				if (!level) begin
					pressed = 1'b1;
					phase_d = PH_PRESSED;
				end else if (below_limit) begin
					count_d = count_q + 1'b1;
					pressed = 1'b1;
				end else begin
					phase_d = PH_RELEASED;
				end
			end
			default: begin
				phase_d = PH_RELEASED;
			end
		endcase
	end

endmodule

// ----- rtl/kdb_merge.sv -----
module kdb_merge
	import kdb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  kdb_pipe_ctl_t       ctl,
	input  logic [NUM_KEYS-1:0] word,
	input  logic [TICKS_W-1:0]  now_ticks,
	input  logic [TICKS_W-1:0]  turn_off_ticks,
	output kdb_pipe_sts_t       sts,
	output logic [RAW_W-1:0]    key_status,
	output logic [RAW_W-1:0]    prev_status,
	output logic                changed,
	output logic                turn_off,
	output logic [TICKS_W-1:0]  event_time
);

	logic [NUM_KEYS-1:0] reported_q;
	logic [TICKS_W-1:0]  hold_start_q;

	logic                valid_s1;
	logic [NUM_KEYS-1:0] word_s1;
	logic [NUM_KEYS-1:0] prev_s1;
	logic [TICKS_W-1:0]  now_s1;
	logic [TICKS_W-1:0]  hold_s1;
	logic                center_s1;

	logic                out_valid_q;
	logic                accept;
	logic                s2_load;
	logic                center_pressed;
	logic                center_edge;
	logic [TICKS_W-1:0]  hold_eff;
	logic [TICKS_W-1:0]  deadline;

	assign s2_load  = valid_s1 && (!out_valid_q || !ctl.out_stall);
	assign sts.in_stall  = valid_s1 && !s2_load;
	assign sts.out_valid = out_valid_q;
	assign accept   = ctl.in_valid && !sts.in_stall;

	// Restart the hold timer on a press edge or while the center key is up.
	assign center_pressed = !word[CENTER_BIT];
	assign center_edge    = center_pressed && reported_q[CENTER_BIT];
	assign hold_eff       = (center_pressed && !center_edge) ? hold_start_q : now_ticks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q   <= '1;
			hold_start_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (accept) begin
				reported_q   <= word;
				hold_start_q <= hold_eff;
				valid_s1     <= 1'b1;
			end else if (s2_load) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1   <= word;
			prev_s1   <= reported_q;
			now_s1    <= now_ticks;
			hold_s1   <= hold_eff;
			center_s1 <= center_pressed;
		end
	end

	assign deadline = hold_s1 + turn_off_ticks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_load) begin
			out_valid_q <= 1'b1;
		end else if (!ctl.out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			key_status  <= word_s1[RAW_W-1:0];
			prev_status <= prev_s1[RAW_W-1:0];
			changed     <= (word_s1 != prev_s1);
			turn_off    <= center_s1 && (now_s1 >= deadline);
			event_time  <= now_s1;
		end
	end

	a_turn_off_needs_center: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && turn_off |-> !key_status[CENTER_BIT])
		else $error("turn_off raised with center key released");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_load |=> valid_s1 && $stable(word_s1) && $stable(now_s1))
		else $error("stage 1 lost a waiting transaction");

	a_reported_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> reported_q == word_s1)
		else $error("reported word does not follow the accepted tick");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ctl.out_stall |-> !s2_load)
		else $error("output register overwritten while stalled");

endmodule

// ----- rtl/keypad_debounce_long_press_top.sv -----
// Keypad debounce with long-press power-off request.
//
// Input channel: one transaction per scan tick, carrying raw_keys (active-low
// key levels, bit i is key i) and now_ticks (free-running time stamp). Each
// transaction produces exactly one output transaction carrying the debounced
// status word, the word reported before it, a changed flag, the turn_off flag
// and the tick's time stamp.
// Throughput: one tick per clock while out_stall is low. Every key has its own debounce
// lane, so all keys advance in the cycle the tick is accepted; the merge stage registers
// the tick, then adds the hold start to turn_off_ticks and compares as it loads the output.
// Configuration: write debounce_limit (index 0) or turn_off_ticks (index 1)
// with cfg_we; write only while no transaction is in flight.
// Reset: all keys released, reported word all ones, hold start zero,
// debounce_limit 3, turn_off_ticks 3000; no output pending.
// Stall: a stalled result holds in the output register; one more tick is
// taken into stage 1, after which in_stall rises until the output drains.
module keypad_debounce_long_press_top
	import kdb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [RAW_W-1:0]      raw_keys,
	input  logic [TICKS_W-1:0]    now_ticks,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [RAW_W-1:0]      key_status,
	output logic [RAW_W-1:0]      prev_status,
	output logic                  changed,
	output logic                  turn_off,
	output logic [TICKS_W-1:0]    event_time
);

	logic [LIMIT_W-1:0]  debounce_limit_q;
	logic [TICKS_W-1:0]  turn_off_ticks_q;
	logic [NUM_KEYS-1:0] pressed;
	logic [NUM_KEYS-1:0] word;
	logic                in_accept;
	kdb_pipe_ctl_t       ctl;
	kdb_pipe_sts_t       sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= DEBOUNCE_LIMIT_RST;
			turn_off_ticks_q <= TURN_OFF_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_TURN_OFF_TICKS: turn_off_ticks_q <= cfg_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign ctl.in_valid  = in_valid;
	assign ctl.out_stall = out_stall;
	assign in_stall      = sts.in_stall;
	assign out_valid     = sts.out_valid;
	assign in_accept     = in_valid && !in_stall;

	// One debounce lane per key; keys beyond the raw field see a released level.
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic level;
		if (k < RAW_W) begin : g_raw
			assign level = raw_keys[k];
		end else begin : g_pad
			assign level = 1'b1;
		end

		kdb_key_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.accept  (in_accept),
			.level   (level),
			.limit   (debounce_limit_q),
			.pressed (pressed[k])
		);
	end

	// Status word is active low: a pressed key reads as zero.
	assign word = ~pressed;

	// Merge lanes, track the center hold time and drive the result register.
	kdb_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.word           (word),
		.now_ticks      (now_ticks),
		.turn_off_ticks (turn_off_ticks_q),
		.sts            (sts),
		.key_status     (key_status),
		.prev_status    (prev_status),
		.changed        (changed),
		.turn_off       (turn_off),
		.event_time     (event_time)
	);

endmodule

// ----- test/keypad_debounce_long_press_top_tb.sv -----
module keypad_debounce_long_press_top_tb
	import kdb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any accepted transaction or register write before the run is abandoned.
	localparam int IDLE_LIMIT = 5000;
	// Cycles the receiver holds off during the back-pressure phase.
	localparam int RX_HOLD_CYCLES = 300;
	// Settle time after the last result.
	localparam int SETTLE_CYCLES = 6;

	typedef struct {
		logic [RAW_W-1:0]   raw;
		logic [TICKS_W-1:0] now;
	} scan_tick_t;

	typedef struct {
		logic [RAW_W-1:0]   key_status;
		logic [RAW_W-1:0]   prev_status;
		logic               changed;
		logic               turn_off;
		logic [TICKS_W-1:0] event_time;
	} key_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [RAW_W-1:0]   raw_keys = '1;
	logic [TICKS_W-1:0] now_ticks = '0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [RAW_W-1:0]   key_status;
	logic [RAW_W-1:0]   prev_status;
	logic               changed;
	logic               turn_off;
	logic [TICKS_W-1:0] event_time;

	keypad_debounce_long_press_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.raw_keys   (raw_keys),
		.now_ticks  (now_ticks),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_status (key_status),
		.prev_status(prev_status),
		.changed    (changed),
		.turn_off   (turn_off),
		.event_time (event_time)
	);

	always #4 clk = ~clk;

	// Scan ticks waiting to be offered, and debounce reports waiting to come out.
	scan_tick_t  tick_q[$];
	key_report_t report_q[$];

	// Shadow of the block: per-key debounce machines, status words and hold timer.
	kdb_phase_t          key_ph[NUM_KEYS];
	logic [LIMIT_W-1:0]  key_cnt[NUM_KEYS];
	logic [NUM_KEYS-1:0] shown_word;
	logic [TICKS_W-1:0]  hold_start;
	logic [LIMIT_W-1:0]  db_limit;
	logic [TICKS_W-1:0]  off_ticks;

	// Idling controls, set by the sequencer at the falling edge.
	bit tx_gap_on = 1'b0;
	bit rx_gap_on = 1'b0;
	int rx_hold_seq = 0;

	int err_cnt = 0;

	// Advance every key's debounce machine by one scan tick and form the report.
	function automatic key_report_t debounce_tick(input logic [RAW_W-1:0] raw,
			input logic [TICKS_W-1:0] now);
		key_report_t         rpt;
		logic [NUM_KEYS-1:0] word;
		logic                lvl;
		logic                down;
		logic [TICKS_W-1:0]  deadline;
		word = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			// keys past the raw field never see a press
			lvl = (k < RAW_W) ? raw[k] : 1'b1;
			down = 1'b0;
			case (key_ph[k])
				PH_RELEASED: begin
					if (!lvl) begin
						key_cnt[k] = '0;
						key_ph[k] = PH_PRESS_DB;
					end
				end
				PH_PRESS_DB: begin
					if (lvl) begin
						key_ph[k] = PH_RELEASED;
					end else if (key_cnt[k] < db_limit) begin
						key_cnt[k] = key_cnt[k] + 1'b1;
					end else begin
						down = 1'b1;
						key_ph[k] = PH_PRESSED;
					end
				end
				PH_PRESSED: begin
					down = 1'b1;
					if (lvl) begin
						key_cnt[k] = '0;
						key_ph[k] = PH_RELEASE_DB;
					end
				end
				default: begin
					if (!lvl) begin
						down = 1'b1;
						key_ph[k] = PH_PRESSED;
					end else if (key_cnt[k] < db_limit) begin
						key_cnt[k] = key_cnt[k] + 1'b1;
						down = 1'b1;
					end else begin
						key_ph[k] = PH_RELEASED;
					end
				end
			endcase
			word[k] = ~down;
		end

		rpt.turn_off = 1'b0;
		if (!word[CENTER_BIT]) begin
			// restart the hold timer on the press edge of the center key
			if (shown_word[CENTER_BIT])
				hold_start = now;
			deadline = hold_start + off_ticks;
			rpt.turn_off = (now >= deadline);
		end else begin
			hold_start = now;
		end

		rpt.key_status = word[RAW_W-1:0];
		rpt.prev_status = shown_word[RAW_W-1:0];
		rpt.changed = (word != shown_word);
		rpt.event_time = now;
		if (word != shown_word)
			shown_word = word;
		return rpt;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Driver: offer pending ticks, predict each one at the edge that accepts it.
	int tx_gap_left = 0;
	scan_tick_t tx_cur;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				report_q.push_back(debounce_tick(raw_keys, now_ticks));
			// the slot is free when nothing is offered or the offer was just taken
			if (!in_valid || !in_stall) begin
				if (tx_gap_left > 0) begin
					in_valid <= 1'b0;
					tx_gap_left <= tx_gap_left - 1;
				end else if (tick_q.size() != 0) begin
					tx_cur = tick_q.pop_front();
					raw_keys <= tx_cur.raw;
					now_ticks <= tx_cur.now;
					in_valid <= 1'b1;
					tx_gap_left <= (tx_gap_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted report against the oldest prediction, then pick stall.
	int rx_stall_left = 0;
	int rx_hold_left = 0;
	int rx_hold_seen = 0;
	key_report_t rx_want;

	always @(posedge clk) begin
		if (out_valid && !out_stall && arst_n) begin
			if (report_q.size() == 0) begin
				$error("report with no prediction waiting: key_status %h", key_status);
				err_cnt++;
			end else begin
				rx_want = report_q.pop_front();
				if (key_status !== rx_want.key_status) begin
					$error("key_status expected %h actual %h", rx_want.key_status, key_status);
					err_cnt++;
				end
				if (prev_status !== rx_want.prev_status) begin
					$error("prev_status expected %h actual %h", rx_want.prev_status,
						prev_status);
					err_cnt++;
				end
				if (changed !== rx_want.changed) begin
					$error("changed expected %b actual %b", rx_want.changed, changed);
					err_cnt++;
				end
				if (turn_off !== rx_want.turn_off) begin
					$error("turn_off expected %b actual %b", rx_want.turn_off, turn_off);
					err_cnt++;
				end
				if (event_time !== rx_want.event_time) begin
					$error("event_time expected %h actual %h", rx_want.event_time,
						event_time);
					err_cnt++;
				end
			end
		end

		if (rx_hold_seq != rx_hold_seen) begin
			// start a long hold-off so the block fills and stalls its input
			rx_hold_seen <= rx_hold_seq;
			rx_hold_left <= RX_HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_stall <= 1'b1;
		end else if (rx_stall_left > 0) begin
			rx_stall_left <= rx_stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (rx_gap_on && $urandom_range(0, 9) < 3)
				rx_stall_left <= pick_gap();
		end
	end

	// Watchdog: abandon the run when nothing moves for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("keypad_debounce_long_press_top test failed");
			$finish;
		end
	end

	// Queue n ticks of one raw pattern with consecutive time stamps.
	task automatic queue_ticks(input logic [RAW_W-1:0] raw, input logic [TICKS_W-1:0] now0,
			input int n);
		scan_tick_t t;
		for (int i = 0; i < n; i++) begin
			t.raw = raw;
			t.now = now0 + i;
			tick_q.push_back(t);
		end
	endtask

	// Random walk of key levels: each key holds a level for a random run, with rare
	// one-tick glitches; a share of ticks are pure noise.
	logic [RAW_W-1:0]   walk_lvl = '1;
	int                 walk_run[RAW_W];
	logic [TICKS_W-1:0] walk_time = '0;

	task automatic queue_walk(input int n, input int max_run, input int noise_pct,
			input int step_max);
		scan_tick_t t;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				t.raw = RAW_W'($urandom);
				t.now = $urandom;
			end else begin
				for (int k = 0; k < RAW_W; k++) begin
					if (walk_run[k] <= 0) begin
						walk_lvl[k] = ~walk_lvl[k];
						walk_run[k] = $urandom_range(1, max_run);
					end else begin
						walk_run[k]--;
					end
					t.raw[k] = walk_lvl[k] ^ ($urandom_range(0, 49) == 0);
				end
				walk_time = walk_time + $urandom_range(0, step_max);
				t.now = walk_time;
			end
			tick_q.push_back(t);
		end
	endtask

	// Hold the sender until every predicted report has come out, then let the block settle.
	task automatic drain();
		while (tick_q.size() != 0 || in_valid || report_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEBOUNCE_LIMIT)
			db_limit = val[LIMIT_W-1:0];
		else
			off_ticks = val[TICKS_W-1:0];
		@(negedge clk);
	endtask

	initial begin
		// reset state of the shadow
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_ph[k] = PH_RELEASED;
			key_cnt[k] = '0;
		end
		for (int k = 0; k < RAW_W; k++)
			walk_run[k] = 0;
		shown_word = '1;
		hold_start = '0;
		db_limit = DEBOUNCE_LIMIT_RST;
		off_ticks = TURN_OFF_TICKS_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset settings: time stamp extremes, full press and release,
		// a release glitch, turn-off exactly at the deadline and a wrapping deadline.
		tx_gap_on = 1'b1;
		rx_gap_on = 1'b1;
		queue_ticks(7'h7f, 32'h0000_0000, 1);
		queue_ticks(7'h7f, 32'hffff_ffff, 1);
		queue_ticks(7'h00, 32'd100, 5);
		queue_ticks(7'h00, 32'd3103, 2);
		queue_ticks(7'h7f, 32'd3200, 1);
		queue_ticks(7'h00, 32'd3201, 1);
		queue_ticks(7'h7f, 32'd3300, 5);
		queue_ticks(7'h3f, 32'hffff_ff00, 5);
		queue_ticks(7'h7f, 32'hffff_ff10, 5);
		drain();
		queue_walk(250, 12, 5, 30);
		drain();

		// Zero limit, zero hold time: accept a level on its second tick.
		tx_gap_on = 1'b0;
		rx_gap_on = 1'b0;
		write_reg(REG_DEBOUNCE_LIMIT, 32'd0);
		write_reg(REG_TURN_OFF_TICKS, 32'd0);
		queue_ticks(7'h00, 32'd10, 2);
		queue_ticks(7'h7f, 32'd20, 2);
		queue_ticks(7'h2a, 32'd30, 1);
		queue_ticks(7'h55, 32'd31, 1);
		queue_ticks(7'h2a, 32'd32, 1);
		queue_ticks(7'h55, 32'd33, 1);
		queue_walk(250, 4, 5, 5);
		drain();

		// Largest limit and largest hold time: long steady runs to get through debounce.
		tx_gap_on = 1'b1;
		write_reg(REG_DEBOUNCE_LIMIT, 32'd255);
		write_reg(REG_TURN_OFF_TICKS, 32'hffff_ffff);
		queue_walk(400, 300, 2, 3);
		drain();

		// Small random settings with a long receiver hold-off while the sender keeps going.
		rx_gap_on = 1'b1;
		write_reg(REG_DEBOUNCE_LIMIT, $urandom_range(1, 6));
		write_reg(REG_TURN_OFF_TICKS, $urandom_range(20, 200));
		queue_walk(300, 30, 5, 8);
		rx_hold_seq = rx_hold_seq + 1;
		drain();

		// No idling, time stamps near the wrap and a random hold time.
		tx_gap_on = 1'b0;
		rx_gap_on = 1'b0;
		write_reg(REG_DEBOUNCE_LIMIT, 32'd2);
		write_reg(REG_TURN_OFF_TICKS, $urandom);
		walk_time = 32'hffff_f000;
		queue_walk(300, 40, 5, 40);
		drain();

		if (err_cnt == 0 && report_q.size() == 0)
			$display("keypad_debounce_long_press_top test passed");
		else
			$display("keypad_debounce_long_press_top test failed");
		$finish;
	end

endmodule
